[hw/rtl/hmts_pkg.sv]
// Shared types, constants and codes for the heightmap triangle height sampler.
`timescale 1ns / 1ps
package hmts_pkg;

  // Field widths
  localparam int H_W    = 24;   // signed Q15.8 height
  localparam int ADDR_W = 16;   // height store address
  localparam int POS_W  = 16;   // signed Q7.8 position
  localparam int DIM_W  = 9;    // map width / height registers
  localparam int CMD_W  = 2;

  localparam int STORE_DEPTH = 1 << ADDR_W;

  // Defaults for the top-level parameters
  localparam int SIDE_DEF      = 256;
  localparam int FRAC_BITS_DEF = 8;

  // Queue depths
  localparam int MID_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH = 2;

  // Saturation limits of the result
  localparam int H_MAX_VAL = 8388607;
  localparam int H_MIN_VAL = -8388608;

  // Configuration port
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_MAP_READY  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] MAP_DIM_RST = 9'd256;

  // Input mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Input beat
  typedef struct packed {
    logic                    mode;
    logic [ADDR_W-1:0]       entry_index;
    logic signed [H_W-1:0]   entry_height;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic signed [H_W-1:0] height_out;
    logic                  in_map;
  } out_item_t;

  // Work classes handed from front to back
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_ZERO  = 2'd2
  } cmd_t;

  // Back-end sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_ZERO,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MULB,
    ST_SUM
  } back_state_t;

endpackage

[hw/rtl/hmts_fifo.sv]
// Small first-word-fall-through queue built from a register array.
`timescale 1ns / 1ps
module hmts_fifo #(
  parameter int WIDTH = $bits(hmts_pkg::out_item_t),
  parameter int DEPTH = hmts_pkg::OUT_Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  import hmts_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // pointer and count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/hmts_front.sv]
// Front end: takes input beats, locates the grid cell and classifies the work.
`timescale 1ns / 1ps
module hmts_front #(
  parameter int SIDE      = hmts_pkg::SIDE_DEF,
  parameter int FRAC_BITS = hmts_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  hmts_pkg::in_item_t                 in_data,
  input  logic                               map_ready,
  input  logic [hmts_pkg::DIM_W-1:0]         map_width,
  input  logic [hmts_pkg::DIM_W-1:0]         map_height,
  output logic                               q_push,
  input  logic                               q_full,
  output hmts_pkg::cmd_t                     q_cmd,
  output logic [hmts_pkg::ADDR_W-1:0]        q_addr,
  output logic signed [hmts_pkg::H_W-1:0]    q_height,
  output logic                               q_upper,
  output logic signed [FRAC_BITS+1:0]        q_wa,
  output logic signed [FRAC_BITS+1:0]        q_wb
);
  import hmts_pkg::*;

  localparam int ONE      = 1 << FRAC_BITS;
  localparam int HALF     = (SIDE / 2) * ONE;
  localparam int LOG_SIDE = $clog2(SIDE);
  localparam int SX_W     = ((LOG_SIDE + FRAC_BITS) > POS_W ? LOG_SIDE + FRAC_BITS : POS_W) + 2;
  localparam int LX_W     = SX_W - FRAC_BITS;
  localparam int CMP_W    = (LX_W > DIM_W ? LX_W : DIM_W) + 1;
  localparam int W_W      = FRAC_BITS + 2;
  localparam int MUL_W    = DIM_W + $clog2(SIDE + 1) + 1;

  localparam logic signed [SX_W-1:0] HALF_S    = SX_W'(HALF);
  localparam logic signed [SX_W-1:0] NEG_ONE_S = SX_W'(-ONE);
  localparam logic signed [W_W-1:0]  ONE_W     = W_W'(ONE);
  localparam logic signed [W_W:0]    ONE_W1    = (W_W + 1)'(ONE);

  // stage register
  logic                     s1_vld_r, s1_vld_nxt;
  logic                     s1_mode_r;
  logic [ADDR_W-1:0]        s1_index_r;
  logic signed [H_W-1:0]    s1_height_r;
  logic signed [SX_W-1:0]   sx_r, sz_r;
  logic                     acc;

  // cell location
  logic                     neg_x, neg_z, over_x, over_z, in_range;
  logic [LX_W-1:0]          lx, lz;
  logic signed [SX_W-1:0]   base_x, base_z, dx_full, dz_full;
  logic signed [W_W-1:0]    dx, dz;
  logic signed [W_W:0]      dsum;
  logic [DIM_W-1:0]         lx9, lz9;
  logic [ADDR_W-1:0]        a00;

  assign acc        = push && !full;
  assign full       = s1_vld_r && q_full;
  assign q_push     = s1_vld_r && !q_full;
  assign s1_vld_nxt = acc ? 1'b1 : (q_push ? 1'b0 : s1_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // shift the position so the grid starts at zero
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_mode_r   <= in_data.mode;
      s1_index_r  <= in_data.entry_index;
      s1_height_r <= in_data.entry_height;
      sx_r        <= SX_W'(in_data.pos_x) + HALF_S;
      sz_r        <= SX_W'(in_data.pos_z) + HALF_S;
    end
  end

  // truncate toward zero; a sum in (-1,0) still lands in cell 0
  always_comb begin
    neg_x   = (sx_r <= NEG_ONE_S);
    neg_z   = (sz_r <= NEG_ONE_S);
    lx      = sx_r[SX_W-1] ? '0 : LX_W'(sx_r >>> FRAC_BITS);
    lz      = sz_r[SX_W-1] ? '0 : LX_W'(sz_r >>> FRAC_BITS);
    over_x  = (CMP_W'(lx) + CMP_W'(1)) >= CMP_W'(map_width);
    over_z  = (CMP_W'(lz) + CMP_W'(1)) >= CMP_W'(map_height);
    base_x  = signed'(SX_W'(lx) << FRAC_BITS);
    base_z  = signed'(SX_W'(lz) << FRAC_BITS);
    dx_full = sx_r - base_x;
    dz_full = sz_r - base_z;
    dx      = W_W'(dx_full);
    dz      = W_W'(dz_full);
    in_range = map_ready && !neg_x && !neg_z && !over_x && !over_z;
  end

  // triangle choice and weights
  always_comb begin
    dsum    = (W_W + 1)'(dx) + (W_W + 1)'(dz);
    q_upper = (dsum > ONE_W1);
    q_wa    = q_upper ? ONE_W - dx : dx;
    q_wb    = q_upper ? ONE_W - dz : dz;
  end

  // low-corner address, wrapped to the store size
  always_comb begin
    lx9 = DIM_W'(lx);
    lz9 = DIM_W'(lz);
    a00 = ADDR_W'(MUL_W'(lz9) * MUL_W'(SIDE) + MUL_W'(lx9));
  end

  // classify
  always_comb begin
    q_height = s1_height_r;
    if (s1_mode_r == MODE_WRITE) begin
      q_cmd  = CMD_WRITE;
      q_addr = s1_index_r;
    end else if (in_range) begin
      q_cmd  = CMD_QUERY;
      q_addr = a00;
    end else begin
      q_cmd  = CMD_ZERO;
      q_addr = a00;
    end
  end

endmodule

[hw/rtl/hmts_back.sv]
// Back end: height store, corner reads, plane interpolation and saturation.
`timescale 1ns / 1ps
module hmts_back #(
  parameter int SIDE      = hmts_pkg::SIDE_DEF,
  parameter int FRAC_BITS = hmts_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  hmts_pkg::cmd_t                  q_cmd,
  input  logic [hmts_pkg::ADDR_W-1:0]     q_addr,
  input  logic signed [hmts_pkg::H_W-1:0] q_height,
  input  logic                            q_upper,
  input  logic signed [FRAC_BITS+1:0]     q_wa,
  input  logic signed [FRAC_BITS+1:0]     q_wb,
  input  logic                            r_full,
  output logic                            r_push,
  output hmts_pkg::out_item_t             r_data
);
  import hmts_pkg::*;

  localparam int W_W = FRAC_BITS + 2;
  localparam int D_W = H_W + 1;
  localparam int P_W = D_W + W_W;
  localparam int S_W = P_W - FRAC_BITS + 2;

  localparam logic [ADDR_W-1:0]      SIDE_A   = ADDR_W'(SIDE);
  localparam logic [ADDR_W-1:0]      SIDE_A1  = ADDR_W'(SIDE + 1);
  localparam logic signed [S_W-1:0]  SAT_HI   = S_W'(H_MAX_VAL);
  localparam logic signed [S_W-1:0]  SAT_LO   = S_W'(H_MIN_VAL);

  back_state_t st_r, st_nxt;

  logic [ADDR_W-1:0]      addr_base_r, addr_a_r, addr_b_r, mem_addr;
  logic signed [H_W-1:0]  wdata_r, base_r;
  logic signed [W_W-1:0]  wa_r, wb_r;
  logic [H_W-1:0]         mem_rd_r;
  logic                   mem_we;
  logic signed [D_W-1:0]  da_r, db_r, diff_nxt;
  logic signed [P_W-1:0]  pa_r, pb_r;
  logic signed [S_W-1:0]  sum;
  logic signed [H_W-1:0]  sat;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd)
            CMD_WRITE: st_nxt = ST_WRITE;
            CMD_QUERY: st_nxt = ST_RD0;
            CMD_ZERO:  st_nxt = ST_ZERO;
            default:   st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: st_nxt = ST_IDLE;
      ST_ZERO:  st_nxt = r_full ? ST_ZERO : ST_IDLE;
      ST_RD0:   st_nxt = ST_RD1;
      ST_RD1:   st_nxt = ST_RD2;
      ST_RD2:   st_nxt = ST_RD3;
      ST_RD3:   st_nxt = ST_MULB;
      ST_MULB:  st_nxt = ST_SUM;
      ST_SUM:   st_nxt = r_full ? ST_SUM : ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // sum of the base and both shifted products, then clamp
  always_comb begin
    sum = S_W'(base_r) + S_W'(pa_r >>> FRAC_BITS) + S_W'(pb_r >>> FRAC_BITS);
    if (sum > SAT_HI) begin
      sat = H_W'(SAT_HI);
    end else if (sum < SAT_LO) begin
      sat = H_W'(SAT_LO);
    end else begin
      sat = H_W'(sum);
    end
  end

  // outputs of the sequencer
  always_comb begin
    q_pop             = 1'b0;
    mem_we            = 1'b0;
    mem_addr          = addr_base_r;
    r_push            = 1'b0;
    r_data.height_out = '0;
    r_data.in_map     = 1'b0;
    unique case (st_r)
      ST_IDLE:  q_pop = !q_empty;
      ST_WRITE: mem_we = 1'b1;
      ST_ZERO:  r_push = !r_full;
      ST_RD1:   mem_addr = addr_a_r;
      ST_RD2:   mem_addr = addr_b_r;
      ST_SUM: begin
        r_push            = !r_full;
        r_data.height_out = sat;
        r_data.in_map     = 1'b1;
      end
      default: begin
        mem_addr = addr_base_r;
      end
    endcase
  end

  // corner addresses: lower triangle is base h00, A h10, B h01;
  // upper triangle is base h11, A h01, B h10
  always_ff @(posedge clk) begin
    if (q_pop) begin
      wdata_r <= q_height;
      wa_r    <= q_wa;
      wb_r    <= q_wb;
      if (q_cmd == CMD_QUERY && q_upper) begin
        addr_base_r <= q_addr + SIDE_A1;
        addr_a_r    <= q_addr + SIDE_A;
        addr_b_r    <= q_addr + 1'b1;
      end else if (q_cmd == CMD_QUERY) begin
        addr_base_r <= q_addr;
        addr_a_r    <= q_addr + 1'b1;
        addr_b_r    <= q_addr + SIDE_A;
      end else begin
        addr_base_r <= q_addr;
        addr_a_r    <= q_addr;
        addr_b_r    <= q_addr;
      end
    end
  end

  // single-port height store, registered read
  logic [H_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata_r;
    end else begin
      mem_rd_r <= mem[mem_addr];
    end
  end

  assign diff_nxt = D_W'(signed'(mem_rd_r)) - D_W'(base_r);

  // base, differences and products, one step per state
  always_ff @(posedge clk) begin
    case (st_r)
      ST_RD1: base_r <= signed'(mem_rd_r);
      ST_RD2: da_r <= diff_nxt;
      ST_RD3: begin
        db_r <= diff_nxt;
        pa_r <= P_W'(da_r) * P_W'(wa_r);
      end
      ST_MULB: pb_r <= P_W'(db_r) * P_W'(wb_r);
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/heightmap_triangle_height_sampler.sv]
// Top level: config registers, front end, work queue, back end, result queue.
`timescale 1ns / 1ps
// Heightmap triangle height sampler.
// Input queue port (push/full, in_data): a beat either writes one grid height
// (mode write) or asks for the height at (pos_x, pos_z). Writes give no result;
// each query gives exactly one result beat on the output queue port
// (empty/pop, out_data), in input order.
// Configuration goes through the APB port: map_ready at 0x0, map_width at 0x4,
// map_height at 0x8; pready is always high. Change them only when idle.
// The back end finishes one item before it takes the next. A query inside
// the map takes three reads of the single-port height store, two multiplies
// and one sum; a write or an out-of-map query needs no read (a write stores
// its height, an out-of-map query sends a zero result).
// A four-entry work queue sits between the front and back ends and a
// two-entry queue holds finished results, so input keeps flowing while
// out_data waits for pop. When the result queue fills, the back end holds and
// full rises once the work queue backs up.
// Reset empties the queues and sets map_ready=0, map_width=map_height=256.
// The height store is not cleared; load it before use.
module heightmap_triangle_height_sampler #(
  parameter int SIDE      = hmts_pkg::SIDE_DEF,
  parameter int FRAC_BITS = hmts_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  hmts_pkg::in_item_t              in_data,
  output logic                            empty,
  input  logic                            pop,
  output hmts_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hmts_pkg::CFG_AW-1:0]     paddr,
  input  logic [hmts_pkg::CFG_DW-1:0]     pwdata,
  output logic [hmts_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);
  import hmts_pkg::*;

  localparam int W_W   = FRAC_BITS + 2;
  localparam int Q_W   = CMD_W + ADDR_W + H_W + 1 + 2 * W_W;
  localparam int OUT_W = $bits(out_item_t);

  // configuration registers
  logic                 map_ready_r;
  logic [DIM_W-1:0]     map_width_r, map_height_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_ready_r  <= 1'b0;
      map_width_r  <= MAP_DIM_RST;
      map_height_r <= MAP_DIM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAP_READY:  map_ready_r  <= pwdata[0];
        REG_MAP_WIDTH:  map_width_r  <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT: map_height_r <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_MAP_READY:  prdata = CFG_DW'(map_ready_r);
      REG_MAP_WIDTH:  prdata = CFG_DW'(map_width_r);
      REG_MAP_HEIGHT: prdata = CFG_DW'(map_height_r);
      default:        prdata = '0;
    endcase
  end

  // front end
  logic                  f_push, mq_full, mq_empty, b_pop;
  cmd_t                  f_cmd;
  logic [ADDR_W-1:0]     f_addr, b_addr;
  logic signed [H_W-1:0] f_height, b_height;
  logic                  f_upper, b_upper;
  logic signed [W_W-1:0] f_wa, f_wb, b_wa, b_wb;
  logic [CMD_W-1:0]      b_cmd_bits;
  logic [Q_W-1:0]        mq_wdata, mq_rdata;

  hmts_front #(
    .SIDE      (SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .map_ready  (map_ready_r),
    .map_width  (map_width_r),
    .map_height (map_height_r),
    .q_push     (f_push),
    .q_full     (mq_full),
    .q_cmd      (f_cmd),
    .q_addr     (f_addr),
    .q_height   (f_height),
    .q_upper    (f_upper),
    .q_wa       (f_wa),
    .q_wb       (f_wb)
  );

  // work queue between front and back
  assign mq_wdata = {f_cmd, f_addr, f_height, f_upper, f_wa, f_wb};
  assign {b_cmd_bits, b_addr, b_height, b_upper, b_wa, b_wb} = mq_rdata;

  hmts_fifo #(
    .WIDTH (Q_W),
    .DEPTH (MID_Q_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .full  (mq_full),
    .wdata (mq_wdata),
    .pop   (b_pop),
    .empty (mq_empty),
    .rdata (mq_rdata)
  );

  // back end
  logic            r_push, r_full;
  out_item_t       r_data;
  logic [OUT_W-1:0] oq_wdata, oq_rdata;

  hmts_back #(
    .SIDE      (SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (mq_empty),
    .q_pop    (b_pop),
    .q_cmd    (cmd_t'(b_cmd_bits)),
    .q_addr   (b_addr),
    .q_height (b_height),
    .q_upper  (b_upper),
    .q_wa     (b_wa),
    .q_wb     (b_wb),
    .r_full   (r_full),
    .r_push   (r_push),
    .r_data   (r_data)
  );

  // result queue
  assign oq_wdata = r_data;
  assign out_data = out_item_t'(oq_rdata);

  hmts_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .full  (r_full),
    .wdata (oq_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (oq_rdata)
  );

  // a result outside the map always reads as zero height
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.in_map) |-> (out_data.height_out == '0))
    else $error("out-of-map result with nonzero height");

  // front never hands work to a full queue
  a_no_mq_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_push && mq_full))
    else $error("work queue overrun");

  // back end never pushes a result into a full result queue
  a_no_oq_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(r_push && r_full))
    else $error("result queue overrun");

  // back end only takes work that is present
  a_pop_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    b_pop |-> !mq_empty)
    else $error("work queue underrun");

endmodule
